// File: rtl/sss_pkg.sv
package sss_pkg;

  localparam int ADDR_WIDTH_DEF   = 48;
  localparam int SECTOR_WIDTH_DEF = 16;

  localparam logic CFG_SECTOR_BYTES   = 1'b0;
  localparam logic CFG_MEDIUM_SECTORS = 1'b1;

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEG_MUL,
    ST_BEG_BASE,
    ST_BEG_CHK,
    ST_DIV,
    ST_SPAN,
    ST_DIV2,
    ST_FIN,
    ST_OUT
  } state_t;

  // Commands from the sequencer to the shared divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: rtl/sss_divider.sv
module sss_divider import sss_pkg::*; #(
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
  parameter int SECTOR_WIDTH = SECTOR_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  div_ctl_t                ctl,
  input  logic [ADDR_WIDTH-1:0]   dividend,
  input  logic [SECTOR_WIDTH-1:0] divisor,
  output div_sts_t                sts,
  output logic [ADDR_WIDTH-1:0]   quotient,
  output logic [SECTOR_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(ADDR_WIDTH + 1);

  logic [ADDR_WIDTH-1:0]   q_r, q_nxt;
  logic [SECTOR_WIDTH:0]   rem_r, rem_nxt;
  logic [SECTOR_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [SECTOR_WIDTH:0]   trial;
  logic [SECTOR_WIDTH:0]   diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial    = {rem_r[SECTOR_WIDTH-1:0], q_r[ADDR_WIDTH-1]};
    diff     = trial - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(ADDR_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[SECTOR_WIDTH]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[ADDR_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[ADDR_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[SECTOR_WIDTH-1:0];

endmodule

// File: rtl/sector_span_splitter.sv
// Channel | Direction | tuser    | tdata fields (lowest bit first)
// in      | slave     | req_type | start_block, byte_offset, length_bytes, multi_ok
// out     | master    | ok       | span_sector, span_offset, span_bytes, span_whole_sectors
// cfg     | write     | -        | sector_bytes (index 0), medium_sectors (index 1)
// A begin forms two 32x32 products from a shared multiplier, capacity and then base,
// then makes the capacity compares before it raises out_tvalid.
// A next runs the bit-serial divider on the current address, and on a multi-sector span
// with multi_ok set it runs the divider a second time for the whole-sector count; a
// next with nothing left raises out_tvalid without running the divider.
// Reset is synchronous and active low; in_tready is low from acceptance until the FSM is idle
// again after the output transaction, and the output register holds while out_tready is low.
module sector_span_splitter import sss_pkg::*; #(
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
  parameter int SECTOR_WIDTH = SECTOR_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type
  input  logic         in_tuser,
  // start_block[31:0], byte_offset[63:32], length_bytes[95:64], multi_ok[96], zero fill
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ok
  output logic         out_tuser,
  // span_sector[31:0], span_offset[47:32], span_bytes[79:48],
  // span_whole_sectors[111:80]
  output logic [111:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int AW = ADDR_WIDTH;
  localparam int SW = SECTOR_WIDTH;

  state_t state_r, state_nxt;

  logic [15:0]   sector_bytes_r;
  logic [31:0]   medium_sectors_r;
  logic [AW-1:0] cur_addr_r, end_addr_r;
  logic          multi_flag_r;
  logic [SW-1:0] ss_r;

  logic [96:0]   req_r;
  logic [63:0]   cap_r, base_r, prod;
  logic [31:0]   mul_a, mul_b;
  logic          fail_r;
  logic [SW-1:0] ss_in;

  // ok in bit 0, the tdata fields above it.
  logic [112:0]  out_r, out_nxt;
  logic          out_valid_r;

  logic [31:0]   sec_r;
  logic [SW-1:0] insec_r;
  logic [AW-1:0] rem_r;

  div_ctl_t      dctl;
  div_sts_t      dsts;
  logic [AW-1:0] dividend, quot;
  logic [SW-1:0] remd;

  logic [31:0] lba, offs, len;
  logic [64:0] addr, endv, capw;
  logic        beg_ok;
  logic [AW-1:0] bytes_v;
  logic [AW-1:0] ssw;
  logic [AW-1:0] mbytes;

  assign lba  = req_r[31:0];
  assign offs = req_r[63:32];
  assign len  = req_r[95:64];
  assign ss_in = SW'(sector_bytes_r);
  assign ssw   = AW'(ss_r);

  // Shared multiplier: capacity in one cycle, base in the next.
  assign mul_a = (state_r == ST_BEG_MUL) ? medium_sectors_r : lba;
  assign mul_b = 32'(ss_in);
  assign prod  = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    addr   = 65'(base_r) + 65'(offs);
    endv   = addr + 65'(len);
    capw   = 65'(cap_r);
    beg_ok = !fail_r && (65'(offs) < capw - 65'(base_r)) && (65'(len) <= capw - addr)
             && (endv <= 65'({AW{1'b1}}));
  end

  // The second pass divides the remaining byte count for the whole-sector count.
  assign dividend = (state_r == ST_FIN) ? rem_r : cur_addr_r;

  // Bytes of a multi-sector span: the remainder minus its part of a sector.
  assign mbytes = rem_r - AW'(remd);

  sss_divider #(.ADDR_WIDTH(AW), .SECTOR_WIDTH(SW)) u_div (
    .clk, .rst_n, .ctl(dctl), .dividend, .divisor(ss_r),
    .sts(dsts), .quotient(quot), .remainder(remd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == REQ_BEGIN) state_nxt = ST_BEG_MUL;
          else                       state_nxt = ST_DIV;
        end
      end
      ST_BEG_MUL:  state_nxt = ST_BEG_BASE;
      ST_BEG_BASE: state_nxt = ST_BEG_CHK;
      ST_BEG_CHK:  state_nxt = ST_OUT;
      ST_DIV: begin
        if (cur_addr_r >= end_addr_r || ss_r == '0) state_nxt = ST_OUT;
        else                                      state_nxt = ST_SPAN;
      end
      ST_SPAN:  if (dsts.done) state_nxt = ST_FIN;
      ST_FIN: begin
        if (insec_r == '0 && rem_r >= ssw && multi_flag_r) state_nxt = ST_DIV2;
        else                                               state_nxt = ST_OUT;
      end
      ST_DIV2:  if (dsts.done) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dctl.start = 1'b0;
    if (state_r == ST_DIV && !(cur_addr_r >= end_addr_r || ss_r == '0)) dctl.start = 1'b1;
    if (state_r == ST_FIN && insec_r == '0 && rem_r >= ssw && multi_flag_r)
      dctl.start = 1'b1;
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    out_nxt = out_r;
    bytes_v = ssw - AW'(insec_r);
    if (bytes_v > rem_r) bytes_v = rem_r;
    unique case (state_r)
      ST_BEG_CHK: out_nxt = {112'd0, beg_ok};
      ST_DIV:     out_nxt = '0;
      ST_FIN: begin
        if (insec_r == '0 && rem_r >= ssw)
          out_nxt = {32'd1, 32'(ss_r), 16'd0, sec_r, 1'b1};
        else
          out_nxt = {32'd0, bytes_v[31:0], 16'(insec_r), sec_r, 1'b1};
      end
      ST_DIV2: begin
        if (dsts.done)
          out_nxt = {quot[31:0], mbytes[31:0], out_r[48:0]};
      end
      default: out_nxt = out_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      sector_bytes_r   <= 16'd512;
      medium_sectors_r <= '0;
      cur_addr_r       <= '0;
      end_addr_r       <= '0;
      multi_flag_r     <= 1'b0;
      ss_r             <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_SECTOR_BYTES) sector_bytes_r <= cfg_wdata[15:0];
        else                               medium_sectors_r <= cfg_wdata;
      end
      if (state_r == ST_BEG_CHK && beg_ok) begin
        cur_addr_r   <= addr[AW-1:0];
        end_addr_r   <= endv[AW-1:0];
        multi_flag_r <= req_r[96];
        ss_r         <= ss_in;
      end
      if (state_r == ST_FIN) begin
        if (insec_r == '0 && rem_r >= ssw && !multi_flag_r)
          cur_addr_r <= cur_addr_r + ssw;
        else if (!(insec_r == '0 && rem_r >= ssw))
          cur_addr_r <= cur_addr_r + bytes_v;
      end
      if (state_r == ST_DIV2 && dsts.done)
        cur_addr_r <= cur_addr_r + mbytes;
      if (state_r != ST_OUT && state_nxt == ST_OUT) out_valid_r <= 1'b1;
      else if (out_tready)                           out_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) req_r <= in_tdata[96:0];
    if (state_r == ST_BEG_MUL) cap_r <= prod;
    if (state_r == ST_BEG_BASE) base_r <= prod;
    if (state_r == ST_BEG_MUL)
      fail_r <= ss_in == '0 || medium_sectors_r == '0 || len == '0 || lba >= medium_sectors_r;
    if (state_r == ST_DIV) rem_r <= end_addr_r - cur_addr_r;
    if (state_r == ST_SPAN && dsts.done) begin
      sec_r   <= quot[31:0];
      insec_r <= remd;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r[0];
  assign out_tdata  = out_r[112:1];

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_r)) else $error("out dropped");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !dsts.busy) else $error("divider busy in idle");
`endif

endmodule

// File: dv/tb_sector_span_splitter.sv
module tb_sector_span_splitter;
  import sss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 310;

  typedef struct packed {
    logic        req;
    logic [31:0] lba;
    logic [31:0] offs;
    logic [31:0] len;
    logic        multi;
  } span_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] sector;
    logic [15:0] offset;
    logic [31:0] bytes;
    logic [31:0] whole;
  } span_res_t;

  // A row either writes a register or sends a request. When typed is set the
  // expected result is ok_exp with every other field zero.
  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [31:0] cfg_val;
    span_req_t   rq;
    logic        typed;
    logic        ok_exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tuser = 1'b0;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic out_tuser;
  logic [111:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_SECTOR_BYTES;
  logic [31:0] cfg_wdata = '0;

  sector_span_splitter DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block's registers and transfer state.
  logic [15:0] sect_size_reg;
  logic [31:0] medium_reg;
  logic [63:0] cur_byte, end_byte, live_sect_size;
  logic        live_multi;

  span_res_t span_q[$];
  int err_count = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  function automatic span_res_t predict_span(span_req_t r);
    logic [63:0] ss, cnt, cap, base, addr, rem, bytes, whole, ins;
    span_res_t e;
    e = '0;
    if (r.req == REQ_BEGIN) begin
      ss = {48'b0, sect_size_reg};
      cnt = {32'b0, medium_reg};
      if (ss != 0 && cnt != 0 && r.len != 0 && r.lba < cnt) begin
        cap = cnt * ss;
        base = r.lba * ss;
        if (r.offs < cap - base) begin
          addr = base + r.offs;
          if (r.len <= cap - addr && addr + r.len <= ADDR_MAX) begin
            cur_byte = addr;
            end_byte = addr + r.len;
            live_multi = r.multi;
            live_sect_size = ss;
            e.ok = 1'b1;
          end
        end
      end
    end else if (cur_byte < end_byte && live_sect_size != 0) begin
      ins = cur_byte % live_sect_size;
      rem = end_byte - cur_byte;
      if (ins == 0 && rem >= live_sect_size) begin
        whole = live_multi ? rem / live_sect_size : 64'd1;
        bytes = whole * live_sect_size;
      end else begin
        whole = 0;
        bytes = live_sect_size - ins;
        if (bytes > rem) bytes = rem;
      end
      e.ok = 1'b1;
      e.sector = 32'(cur_byte / live_sect_size);
      e.offset = ins[15:0];
      e.bytes = bytes[31:0];
      e.whole = whole[31:0];
      cur_byte = (cur_byte + bytes) & ADDR_MAX;
    end
    return e;
  endfunction

  function automatic span_req_t rand_req();
    span_req_t r;
    r.req = 1'($urandom);
    r.lba = $urandom;
    r.offs = $urandom;
    r.len = $urandom;
    r.multi = 1'($urandom);
    return r;
  endfunction

  task automatic send_req(input span_req_t r, input bit typed, input logic tok);
    span_res_t e;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.req;
    in_tdata <= {7'b0, r.multi, r.len, r.offs, r.lba};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e = predict_span(r);
    if (typed) begin
      e = '0;
      e.ok = tok;
    end
    span_q.push_back(e);
    burst_left--;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SECTOR_BYTES) sect_size_reg = val[15:0];
    else medium_reg = val;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] ss_val, input logic [31:0] med_val);
    span_req_t r;
    logic [63:0] ss, med, lba, room;
    int sent, nexts;
    drain_results();
    write_reg(CFG_SECTOR_BYTES, ss_val);
    write_reg(CFG_MEDIUM_SECTORS, med_val);
    ss = {48'b0, ss_val[15:0]};
    med = {32'b0, med_val};
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 85 && ss != 0 && med != 0) begin
        lba = ($urandom_range(0, 3) == 0) ? med - 1 : {32'b0, $urandom} % med;
        room = (med - lba) * ss;
        r.req = REQ_BEGIN;
        r.lba = lba[31:0];
        r.offs = 32'(({32'b0, $urandom_range(0, 3)} * ss + $urandom_range(0, 7)) % room);
        room = room - r.offs;
        r.len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32'(5 * ss + 7));
        if (r.len > room && $urandom_range(0, 1) == 1)
          r.len = (room > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : room[31:0];
        r.multi = 1'($urandom_range(0, 1));
        send_req(r, 1'b0, 1'b0);
        sent++;
        nexts = $urandom_range(1, 7);
        repeat (nexts) begin
          r = rand_req();
          r.req = REQ_NEXT;
          send_req(r, 1'b0, 1'b0);
          sent++;
        end
      end else begin
        r = rand_req();
        send_req(r, 1'b0, 1'b0);
        sent++;
      end
      if (sent > PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 8) drain_results();
    end
  endtask

  dir_row_t dir_rows[24] = '{
    // Next right after reset, then a begin while the medium size is still zero.
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b1, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd0, 32'd0, 32'd1, 1'b1}, 1'b1, 1'b0},
    '{1'b1, CFG_MEDIUM_SECTORS, 32'd1000, '0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd0, 32'd0, 32'd0, 1'b1}, 1'b1, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd1000, 32'd0, 32'd1, 1'b1}, 1'b1, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd999, 32'd512, 32'd1, 1'b1}, 1'b1, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd998, 32'd0, 32'd1025, 1'b0}, 1'b1, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd2, 32'd100, 32'd2000, 1'b1}, 1'b1, 1'b1},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b1, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd0, 32'd0, 32'd1536, 1'b0}, 1'b1, 1'b1},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    // A zero sector size fails the begin; the earlier transfer goes on.
    '{1'b1, CFG_SECTOR_BYTES, 32'hABCD_0000, '0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'd0, 32'd0, 32'd1, 1'b1}, 1'b1, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    '{1'b1, CFG_SECTOR_BYTES, 32'h0000_FFFF, '0, 1'b0, 1'b0},
    '{1'b1, CFG_MEDIUM_SECTORS, 32'hFFFF_FFFF, '0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_BEGIN, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
      1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0},
    '{1'b0, 1'b0, 32'd0, '{REQ_NEXT, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, 1'b0}
  };

  initial begin
    sect_size_reg = 16'd512;
    medium_reg = 32'd0;
    cur_byte = '0;
    end_byte = '0;
    live_sect_size = '0;
    live_multi = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_results();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].ok_exp);
      end
    end
    run_phase(32'd512, 32'd2048);
    run_phase(32'd1, 32'd64);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(32'd4096, $urandom);
    run_phase({16'hFFFF, 16'($urandom_range(2, 65535))}, $urandom_range(1, 100000));
    run_phase(32'd3, 32'd1);
    drain_results();
    repeat (250) @(posedge clk);
    if (span_q.size() != 0) begin
      $error("%0d expected results never arrived", span_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("** sector_span_splitter: PASSED **");
    end else begin
      $display("** sector_span_splitter: FAILED **");
    end
    $finish;
  end

  // Result checker and output stall pattern.
  always @(posedge clk) begin
    span_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[31:0], out_tdata[47:32], out_tdata[79:48],
             out_tdata[111:80]};
      if (span_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        err_count++;
      end else begin
        want = span_q.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          err_count++;
        end
        if (got.sector !== want.sector) begin
          $error("span_sector: expected %0d, got %0d", want.sector, got.sector);
          err_count++;
        end
        if (got.offset !== want.offset) begin
          $error("span_offset: expected %0d, got %0d", want.offset, got.offset);
          err_count++;
        end
        if (got.bytes !== want.bytes) begin
          $error("span_bytes: expected %0d, got %0d", want.bytes, got.bytes);
          err_count++;
        end
        if (got.whole !== want.whole) begin
          $error("span_whole_sectors: expected %0d, got %0d", want.whole, got.whole);
          err_count++;
        end
      end
    end
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_timer = $urandom_range(50, 400);
    end
    stall_timer--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("** sector_span_splitter: FAILED **");
      $finish;
    end
  end
endmodule
